/* hw/rtl/u8d_pkg.sv */
package u8d_pkg;

  localparam int CpW       = 21;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  localparam logic [CpW-1:0] ReplCp   = 21'h00FFFD;
  localparam logic [7:0]     AsciiLim = 8'h80;
  localparam logic [7:0]     ContMask = 8'hC0;
  localparam logic [7:0]     ContCode = 8'h80;
  localparam logic [7:0]     Lead2Msk = 8'hE0;
  localparam logic [7:0]     Lead2Cod = 8'hC0;
  localparam logic [7:0]     Lead3Msk = 8'hF0;
  localparam logic [7:0]     Lead3Cod = 8'hE0;
  localparam logic [7:0]     Lead4Msk = 8'hF8;
  localparam logic [7:0]     Lead4Cod = 8'hF0;
  localparam logic [7:0]     ContPay  = 8'h3F;
  localparam logic [7:0]     Lead2Pay = 8'h1F;
  localparam logic [7:0]     Lead3Pay = 8'h0F;
  localparam logic [7:0]     Lead4Pay = 8'h07;

  localparam logic [1:0] RemNone = 2'd0;
  localparam logic [1:0] RemOne  = 2'd1;
  localparam logic [1:0] RemTwo  = 2'd2;
  localparam logic [1:0] RemThr  = 2'd3;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_replacement;
    logic           end_of_string;
    logic           last_of_run;
  } result_t;

  typedef struct packed {
    logic           emit;
    result_t        res;
    logic [1:0]     rem;
    logic [CpW-1:0] acc;
  } lead_t;

  // Decode a byte seen while no continuation is expected.
  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t l;
    l.emit = 1'b0;
    l.res  = '{code_point: '0, is_replacement: 1'b0, end_of_string: 1'b0,
               last_of_run: 1'b1};
    l.rem  = RemNone;
    l.acc  = '0;
    if (b < AsciiLim) begin
      l.emit               = 1'b1;
      l.res.code_point     = {{(CpW-8){1'b0}}, b};
      l.res.end_of_string  = (b == 8'h00);
    end else if ((b & Lead2Msk) == Lead2Cod) begin
      l.rem = RemOne;
      l.acc = {{(CpW-8){1'b0}}, b & Lead2Pay};
    end else if ((b & Lead3Msk) == Lead3Cod) begin
      l.rem = RemTwo;
      l.acc = {{(CpW-8){1'b0}}, b & Lead3Pay};
    end else if ((b & Lead4Msk) == Lead4Cod) begin
      l.rem = RemThr;
      l.acc = {{(CpW-8){1'b0}}, b & Lead4Pay};
    end else begin
      l.emit               = 1'b1;
      l.res.code_point     = ReplCp;
      l.res.is_replacement = 1'b1;
    end
    return l;
  endfunction

endpackage

/* hw/rtl/utf8_stream_decoder_unit.sv */
// Lenient UTF-8 decoder: takes one byte per cycle while in_ready is high and
// gives code points. Each accepted byte is decoded in the cycle of its
// transfer against the pending form state; its zero, one or two results enter
// a four-entry result buffer, and out_valid rises the cycle after the transfer.
// The buffer drains one result per cycle while out_ready is high; in_ready
// stays high while it has two free entries, so input stalls when fewer are
// free, as when the output is held off or broken forms give two results each.
module utf8_stream_decoder_unit
  import u8d_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte_in,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [CpW-1:0] out_code_point,
  output logic           out_is_replacement,
  output logic           out_end_of_string,
  output logic           out_last_of_run
);

  logic [1:0]     rem_r, rem_nxt;
  logic [CpW-1:0] acc_r, acc_nxt;
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  result_t         buf_r [FifoDepth];

  logic     push, pop, is_cont;
  logic [1:0] n_res;
  result_t  res0, res1;
  lead_t    ld;
  logic [CpW-1:0] acc_sh;

  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count_r <= CntW'(FifoDepth - 2));
  assign is_cont  = ((in_byte_in & ContMask) == ContCode);
  assign acc_sh   = {acc_r[CpW-7:0], in_byte_in[5:0]};
  assign ld       = lead_decode(in_byte_in);

  // Decode the incoming byte against the pending form
  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    n_res   = 2'd0;
    res0    = ld.res;
    res1    = ld.res;
    if (rem_r != RemNone) begin
      if (is_cont) begin
        rem_nxt = rem_r - 2'd1;
        acc_nxt = acc_sh;
        if (rem_r == RemOne) begin
          n_res = 2'd1;
          res0  = '{code_point: acc_sh, is_replacement: 1'b0,
                    end_of_string: (acc_sh == '0), last_of_run: 1'b1};
          acc_nxt = '0;
        end
      end else begin
        // drop the broken form, then treat this byte as a lead
        res0    = '{code_point: ReplCp, is_replacement: 1'b1,
                    end_of_string: 1'b0, last_of_run: !ld.emit};
        res1    = ld.res;
        n_res   = ld.emit ? 2'd2 : 2'd1;
        rem_nxt = ld.rem;
        acc_nxt = ld.acc;
      end
    end else begin
      res0    = ld.res;
      n_res   = ld.emit ? 2'd1 : 2'd0;
      rem_nxt = ld.rem;
      acc_nxt = ld.acc;
    end
  end

  // Advance decoder state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= RemNone;
      acc_r <= '0;
    end else if (push) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      count_r <= count_r + (push ? CntW'(n_res) : CntW'(0)) - CntW'(pop);
    end
  end

  // Result buffer storage
  always_ff @(posedge clk) begin
    if (push && n_res != 2'd0) begin
      buf_r[wr_ptr_r] <= res0;
    end
    if (push && n_res == 2'd2) begin
      buf_r[wr_ptr_r + PtrW'(1)] <= res1;
    end
  end

  assign out_valid          = (count_r != '0);
  assign out_code_point     = buf_r[rd_ptr_r].code_point;
  assign out_is_replacement = buf_r[rd_ptr_r].is_replacement;
  assign out_end_of_string  = buf_r[rd_ptr_r].end_of_string;
  assign out_last_of_run    = buf_r[rd_ptr_r].last_of_run;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(FifoDepth))
    else $error("result buffer count overflow");

  a_first_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> out_is_replacement)
    else $error("non-final result is not a replacement");

  a_eos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_string) |-> (out_code_point == '0 && !out_is_replacement))
    else $error("end of string with nonzero code point");

  a_ascii_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_byte_in < AsciiLim) |=> (rem_r == RemNone && acc_r == '0))
    else $error("ascii byte left a pending form");

  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && n_res != 2'd0) |=> out_valid)
    else $error("result pushed but output not valid");

endmodule

/* tb/utf8_stream_decoder_unit_tb.sv */
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_tb;
  import u8d_pkg::*;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SLOW
  } rx_pattern_e;

  localparam int RandomBytes = 1750;
  localparam int TailCycles  = 20;
  localparam int HoldStart   = 600;
  localparam int HoldEnd     = 900;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     in_byte_in = 8'h00;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CpW-1:0] out_code_point;
  logic           out_is_replacement;
  logic           out_end_of_string;
  logic           out_last_of_run;

  // bytes waiting to be offered, and code points the decoder still owes
  logic [7:0] text_bytes_q[$];
  result_t    cp_expect_q[$];

  // shadow of the decoder's pending form
  logic [1:0]     form_left = RemNone;
  logic [CpW-1:0] form_acc = '0;

  int err_cnt = 0;
  logic in_taken = 1'b0;

  // sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int rx_cyc = 0;
  int rx_pattern_left = 0;
  rx_pattern_e rx_pattern = RX_FREE;

  utf8_stream_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_is_replacement(out_is_replacement),
    .out_end_of_string (out_end_of_string),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // queue one decoded code point; last_of_run is fixed up per byte
  task automatic emit_cp(input logic [CpW-1:0] cp, input logic repl);
    result_t r;
    r.code_point     = cp;
    r.is_replacement = repl;
    r.end_of_string  = !repl && (cp == '0);
    r.last_of_run    = 1'b0;
    cp_expect_q.push_back(r);
  endtask

  // handle a byte while no continuation is pending; returns results added
  task automatic start_form(input logic [7:0] b, inout int n);
    if (b < AsciiLim) begin
      emit_cp({{(CpW-8){1'b0}}, b}, 1'b0);
      n++;
    end else if ((b & Lead2Msk) == Lead2Cod) begin
      form_acc  = {{(CpW-8){1'b0}}, b & Lead2Pay};
      form_left = RemOne;
    end else if ((b & Lead3Msk) == Lead3Cod) begin
      form_acc  = {{(CpW-8){1'b0}}, b & Lead3Pay};
      form_left = RemTwo;
    end else if ((b & Lead4Msk) == Lead4Cod) begin
      form_acc  = {{(CpW-8){1'b0}}, b & Lead4Pay};
      form_left = RemThr;
    end else begin
      emit_cp(ReplCp, 1'b1);
      n++;
    end
  endtask

  // advance the shadow decoder by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    int n;
    result_t r;
    n = 0;
    if (form_left != RemNone) begin
      if ((b & ContMask) == ContCode) begin
        form_acc  = {form_acc[CpW-7:0], b[5:0]};
        form_left = form_left - 2'd1;
        if (form_left == RemNone) begin
          emit_cp(form_acc, 1'b0);
          form_acc = '0;
          n++;
        end
      end else begin
        // broken form: replace it, then treat this byte as a new lead
        emit_cp(ReplCp, 1'b1);
        form_left = RemNone;
        form_acc  = '0;
        n++;
        start_form(b, n);
      end
    end else begin
      form_acc = '0;
      start_form(b, n);
    end
    if (n > 0) begin
      r = cp_expect_q.pop_back();
      r.last_of_run = 1'b1;
      cp_expect_q.push_back(r);
    end
  endtask

  // sender: bursts of transfers with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left   <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the offered byte until its transfer
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (text_bytes_q.size() > 0) begin
      in_valid   <= 1'b1;
      in_byte_in <= text_bytes_q.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: switch between stall patterns, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready       <= 1'b0;
      rx_cyc          <= 0;
      rx_pattern_left <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_pattern_left == 0) begin
        rx_pattern      <= rx_pattern_e'($urandom_range(0, 2));
        rx_pattern_left <= $urandom_range(10, 80);
      end else begin
        rx_pattern_left <= rx_pattern_left - 1;
      end
      if (rx_cyc >= HoldStart && rx_cyc < HoldEnd) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_FREE: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // check each result transfer, then predict from each byte transfer
  always @(posedge clk) begin
    result_t got;
    result_t want;
    got.code_point     = out_code_point;
    got.is_replacement = out_is_replacement;
    got.end_of_string  = out_end_of_string;
    got.last_of_run    = out_last_of_run;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (cp_expect_q.size() == 0) begin
        $display("%0t: unexpected result cp=%h repl=%b eos=%b last=%b", $time,
                 got.code_point, got.is_replacement, got.end_of_string, got.last_of_run);
        err_cnt++;
      end else begin
        want = cp_expect_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected cp=%h repl=%b eos=%b last=%b,",
                   $time, want.code_point, want.is_replacement, want.end_of_string,
                   want.last_of_run, " got cp=%h repl=%b eos=%b last=%b",
                   got.code_point, got.is_replacement,
                   got.end_of_string, got.last_of_run);
          err_cnt++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      decode_byte(in_byte_in);
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [7:0] b;
    int pick;
    int len;
    int nc;
    // extremes, bad leads, every form length, overlong zero, broken forms
    text_bytes_q = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,
                     8'hC2, 8'hA9,
                     8'hE2, 8'h82, 8'hAC,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hC0, 8'h80,
                     8'hC2, 8'h41,
                     8'hE0, 8'h80, 8'hFF,
                     8'hF0, 8'h90, 8'h00};
    while (text_bytes_q.size() < RandomBytes + 24) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (pick < 15) begin
        // noise byte
        text_bytes_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (pick >= 85 && len == 1) len = $urandom_range(2, 4);
        case (len)
          1: b = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 127));
          2: b = Lead2Cod | 8'($urandom_range(0, 31));
          3: b = Lead3Cod | 8'($urandom_range(0, 15));
          default: b = Lead4Cod | 8'($urandom_range(0, 7));
        endcase
        text_bytes_q.push_back(b);
        // a broken form stops short and then gets a byte that is no continuation
        nc = (pick >= 85) ? $urandom_range(0, len - 2) : len - 1;
        repeat (nc) text_bytes_q.push_back(ContCode | 8'($urandom_range(0, 63)));
        if (pick >= 85) begin
          do b = 8'($urandom_range(0, 255)); while ((b & ContMask) == ContCode);
          text_bytes_q.push_back(b);
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (text_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("utf8_stream_decoder_unit_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("utf8_stream_decoder_unit_tb: done, errors");
    $finish;
  end

endmodule
